@@ hw/rtl/dfs_maze_carver_defines.svh @@
// Assertion macros shared by the maze carver RTL.
`ifndef DFS_MAZE_CARVER_DEFINES_SVH
`define DFS_MAZE_CARVER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define DMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define DMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dmc_pkg.sv @@
// Types, codes and helper functions for the maze carver.
package dmc_pkg;

  localparam int COORD_W = 6;
  localparam int EPOCH_W = 4;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CARVED  = 3'd0,
    ST_BACK    = 3'd1,
    ST_DONE    = 3'd2,
    ST_STARTED = 3'd3,
    ST_REJECT  = 3'd4,
    ST_READ    = 3'd5
  } status_t;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } cell_t;

  typedef struct packed {
    logic       any;
    logic [1:0] dir;
  } pick_t;

  localparam cell_t ENTRY_CELL = '{y: COORD_W'(0), x: COORD_W'(1)};
  localparam cell_t START_CELL = '{y: COORD_W'(1), x: COORD_W'(1)};

  // Column step of a direction, two cells
  function automatic logic signed [2:0] step_dx(input logic [1:0] dir);
    case (dir)
      DIR_RIGHT: return 3'sd2;
      DIR_LEFT:  return -3'sd2;
      default:   return 3'sd0;
    endcase
  endfunction

  // Row step of a direction, two cells
  function automatic logic signed [2:0] step_dy(input logic [1:0] dir);
    case (dir)
      DIR_UP:   return -3'sd2;
      DIR_DOWN: return 3'sd2;
      default:  return 3'sd0;
    endcase
  endfunction

  // Remainder by three: base-4 digits sum to the same remainder
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [3:0] s1;
    logic [2:0] s2;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    s1 = 4'(s[4:2]) + 4'(s[1:0]);
    s2 = 3'(s1[3:2]) + 3'(s1[1:0]);
    if (s2 >= 3'd3) begin
      s2 = s2 - 3'd3;
    end
    return s2[1:0];
  endfunction

endpackage

@@ hw/rtl/dmc_pick.sv @@
// Neighbor chooser: picks the candidate direction selected by the random value.
module dmc_pick (
  input  logic [3:0]     cand,
  input  logic [1:0]     rnd_lo,
  input  logic [1:0]     rnd_mod3,
  output dmc_pkg::pick_t pick
);
  import dmc_pkg::*;

  logic [2:0] cnt;
  logic [1:0] idx;
  logic [1:0] seen;

  // Reduce the random value by the candidate count, then find that candidate
  always_comb begin
    cnt = 3'($countones(cand));
    case (cnt)
      3'd2:    idx = {1'b0, rnd_lo[0]};
      3'd3:    idx = rnd_mod3;
      3'd4:    idx = rnd_lo;
      default: idx = 2'd0;
    endcase
    pick.any = (cand != 4'b0000);
    pick.dir = DIR_UP;
    seen     = 2'd0;
    for (int d = 0; d < 4; d++) begin
      if (cand[d]) begin
        if (seen == idx) begin
          pick.dir = 2'(d);
        end
        seen = seen + 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/dfs_maze_carver.sv @@
// Top level of the depth-first maze carver with its map and path stack memories.
//
// Input beats (in_valid/in_ready) carry an action: start, carve step or cell read.
// Every beat but the unused action gives one output beat (out_valid/out_ready).
// The user writes grid_size through cfg_we/cfg_wdata only while no beat is in
// flight; the block does not enforce this. Four neighbor reads and two map
// writes of a carve step share the single map memory port, one access a cycle
// unless the receiver stalls. A backtrack makes the same reads, then reads the
// path stack. A start writes three map cells while the map epoch can advance.
// Every fifteenth start, and once after reset, the map is swept clear first: all
// MAX_SIDE*MAX_SIDE entries (4096 at the default size), one entry a cycle, with
// in_ready low throughout. Configuration writes are taken during the sweep as at
// any other time. After reset the grid size is 63 and the path stack is empty.
// One item is worked on at a time; the next is accepted as soon as the result is
// placed in the output register. When the receiver stalls, a result that is done
// waits in its last state until the output register frees up.
`include "dfs_maze_carver_defines.svh"

module dfs_maze_carver #(
  parameter int MAX_SIDE      = 64,
  parameter int STACK_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] random_value,
  input  logic [5:0]  read_x,
  input  logic [5:0]  read_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [5:0]  cell_x,
  output logic [5:0]  cell_y,
  output logic [5:0]  gap_x,
  output logic [5:0]  gap_y,
  output logic        cell_open
);
  import dmc_pkg::*;

  localparam int MAP_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW        = $clog2(MAP_DEPTH);
  localparam int SIW       = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
  localparam int CNTW      = $clog2(STACK_ENTRIES + 1);

  localparam logic [AW-1:0]       MAP_LAST   = AW'(MAP_DEPTH - 1);
  localparam logic [CNTW-1:0]     STACK_FULL = CNTW'(STACK_ENTRIES);
  localparam logic signed [9:0]   SIDE_LIM   = 10'(MAX_SIDE);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_OPEN  = 9'b000000100,
    S_LOOK  = 9'b000001000,
    S_PICK  = 9'b000010000,
    S_POP   = 9'b000100000,
    S_CELL  = 9'b001000000,
    S_READ  = 9'b010000000,
    S_REPLY = 9'b100000000
  } state_t;

  state_t               state;
  logic [5:0]           grid_size;
  logic [EPOCH_W-1:0]   epoch;
  logic [AW-1:0]        clear_addr;
  logic                 clear_then_open;
  logic [1:0]           open_step;
  logic [1:0]           look_dir;
  cell_t                top_q;
  cell_t                new_q;
  cell_t                gap_q;
  logic [CNTW-1:0]      stack_count;
  logic [2:0]           cand_q;
  logic [1:0]           rnd_lo;
  logic [1:0]           rnd_mod3;
  logic                 rd_inrange;
  status_t              res_status;

  // Map memory: one epoch tag per cell, open when the tag matches the epoch
  logic [EPOCH_W-1:0]   map_mem [MAP_DEPTH];
  logic [EPOCH_W-1:0]   map_rtag;
  logic                 map_we;
  logic                 map_re;
  logic [AW-1:0]        map_addr;
  logic [EPOCH_W-1:0]   map_wtag;

  // Path stack memory
  cell_t                stack_mem [STACK_ENTRIES];
  cell_t                stack_rdata;
  logic                 stack_we;
  logic                 stack_re;
  logic [SIW-1:0]       stack_addr;
  cell_t                stack_wdata;

  logic                 accept;
  logic                 slot_free;
  logic                 out_load;
  status_t              out_status;
  logic signed [9:0]    n_last;
  logic signed [9:0]    nb_x [4];
  logic signed [9:0]    nb_y [4];
  cell_t                nb_cell [4];
  logic [3:0]           nb_ok;
  logic                 map_open;
  logic [3:0]           cand_all;
  pick_t                pick;
  cell_t                sel_wall;
  cell_t                exit_cell;
  logic                 size_ok;
  logic                 read_inrange;
  logic                 pop_has_below;
  logic                 gap_mid;

  function automatic logic [AW-1:0] cell_addr(input cell_t c);
    logic [31:0] lin;
    lin = 32'(c.y) * 32'(MAX_SIDE) + 32'(c.x);
    return lin[AW-1:0];
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign map_open  = (map_rtag == epoch);

  assign size_ok = (grid_size >= 6'd3) && grid_size[0] &&
                   ($signed({4'b0000, grid_size}) <= SIDE_LIM);
  assign read_inrange = ($signed({4'b0000, read_x}) < SIDE_LIM) &&
                        ($signed({4'b0000, read_y}) < SIDE_LIM);
  assign pop_has_below = (stack_count >= CNTW'(2));
  assign exit_cell.x   = grid_size - 6'd1;
  assign exit_cell.y   = grid_size - 6'd2;

  // Neighbors two cells away and their bounds against the live grid size
  always_comb begin
    logic signed [2:0] dx;
    logic signed [2:0] dy;
    n_last = $signed({4'b0000, grid_size}) - 10'sd1;
    for (int d = 0; d < 4; d++) begin
      dx = step_dx(2'(d));
      dy = step_dy(2'(d));
      nb_x[d] = $signed({4'b0000, top_q.x}) + $signed({{7{dx[2]}}, dx});
      nb_y[d] = $signed({4'b0000, top_q.y}) + $signed({{7{dy[2]}}, dy});
      nb_cell[d].x = nb_x[d][5:0];
      nb_cell[d].y = nb_y[d][5:0];
      nb_ok[d] = (nb_x[d] > 10'sd0) && (nb_x[d] < n_last) && (nb_x[d] < SIDE_LIM) &&
                 (nb_y[d] > 10'sd0) && (nb_y[d] < n_last) && (nb_y[d] < SIDE_LIM);
    end
  end

  // Last neighbor's tag arrives in the pick cycle
  assign cand_all = {nb_ok[3] && !map_open, cand_q};

  dmc_pick u_pick (
    .cand     (cand_all),
    .rnd_lo   (rnd_lo),
    .rnd_mod3 (rnd_mod3),
    .pick     (pick)
  );

  // Wall cell halfway toward the chosen neighbor
  always_comb begin
    logic signed [2:0] hx;
    logic signed [2:0] hy;
    hx = step_dx(pick.dir) >>> 1;
    hy = step_dy(pick.dir) >>> 1;
    sel_wall.x = top_q.x + {{3{hx[2]}}, hx};
    sel_wall.y = top_q.y + {{3{hy[2]}}, hy};
  end

  // Memory port control and result loading
  always_comb begin
    map_we      = 1'b0;
    map_re      = 1'b0;
    map_addr    = '0;
    map_wtag    = epoch;
    stack_we    = 1'b0;
    stack_re    = 1'b0;
    stack_addr  = '0;
    stack_wdata = START_CELL;
    out_load    = 1'b0;
    out_status  = res_status;
    unique case (state)
      S_IDLE: begin
        if (accept && (action == ACT_STEP) && (stack_count != '0)) begin
          map_re   = nb_ok[0];
          map_addr = cell_addr(nb_cell[0]);
        end else if (accept && (action == ACT_READ)) begin
          map_re   = read_inrange;
          map_addr = cell_addr('{y: read_y, x: read_x});
        end
      end
      S_CLEAR: begin
        map_we   = 1'b1;
        map_addr = clear_addr;
        map_wtag = '0;
      end
      S_OPEN: begin
        case (open_step)
          2'd0:    map_addr = cell_addr(ENTRY_CELL);
          2'd1:    map_addr = cell_addr(START_CELL);
          default: map_addr = cell_addr(exit_cell);
        endcase
        map_we     = (open_step != 2'd2) || slot_free;
        stack_we   = (open_step == 2'd2) && slot_free;
        out_load   = (open_step == 2'd2) && slot_free;
        out_status = ST_STARTED;
      end
      S_LOOK: begin
        map_re   = nb_ok[look_dir];
        map_addr = cell_addr(nb_cell[look_dir]);
      end
      S_PICK: begin
        if (pick.any) begin
          map_we   = 1'b1;
          map_addr = cell_addr(sel_wall);
        end else begin
          stack_re   = pop_has_below;
          stack_addr = SIW'(stack_count - CNTW'(2));
        end
      end
      S_POP: begin
        out_load   = slot_free;
        out_status = ST_BACK;
      end
      S_CELL: begin
        map_we      = slot_free;
        map_addr    = cell_addr(new_q);
        stack_we    = slot_free && (stack_count < STACK_FULL);
        stack_addr  = SIW'(stack_count);
        stack_wdata = new_q;
        out_load    = slot_free;
        out_status  = ST_CARVED;
      end
      S_READ: begin
        out_load   = slot_free;
        out_status = ST_READ;
      end
      S_REPLY: begin
        out_load = slot_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Map memory, single port
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_addr] <= map_wtag;
    end else if (map_re) begin
      map_rtag <= map_mem[map_addr];
    end
  end

  // Path stack memory, single port
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_addr] <= stack_wdata;
    end else if (stack_re) begin
      stack_rdata <= stack_mem[stack_addr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clear_addr      <= '0;
      clear_then_open <= 1'b0;
      epoch           <= '0;
      stack_count     <= '0;
      out_valid       <= 1'b0;
      grid_size       <= 6'd63;
      look_dir        <= 2'd0;
      open_step       <= 2'd0;
    end else begin
      if (cfg_we) begin
        grid_size <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rnd_lo     <= random_value[1:0];
            rnd_mod3   <= mod3_16(random_value);
            rd_inrange <= read_inrange;
            case (action)
              ACT_START: begin
                if (!size_ok) begin
                  res_status <= ST_REJECT;
                  state      <= S_REPLY;
                end else if (epoch == EPOCH_LAST) begin
                  clear_addr      <= '0;
                  clear_then_open <= 1'b1;
                  state           <= S_CLEAR;
                end else begin
                  epoch     <= epoch + EPOCH_W'(1);
                  open_step <= 2'd0;
                  state     <= S_OPEN;
                end
              end
              ACT_STEP: begin
                if (stack_count == '0) begin
                  res_status <= ST_DONE;
                  state      <= S_REPLY;
                end else begin
                  look_dir <= 2'd1;
                  state    <= S_LOOK;
                end
              end
              ACT_READ: begin
                state <= S_READ;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_CLEAR: begin
          if (clear_addr == MAP_LAST) begin
            epoch           <= EPOCH_FIRST;
            open_step       <= 2'd0;
            clear_then_open <= 1'b0;
            state           <= clear_then_open ? S_OPEN : S_IDLE;
          end else begin
            clear_addr <= clear_addr + AW'(1);
          end
        end
        S_OPEN: begin
          if (open_step == 2'd2) begin
            if (slot_free) begin
              stack_count <= CNTW'(1);
              top_q       <= START_CELL;
              state       <= S_IDLE;
            end
          end else begin
            open_step <= open_step + 2'd1;
          end
        end
        S_LOOK: begin
          cand_q[look_dir - 2'd1] <= nb_ok[look_dir - 2'd1] && !map_open;
          look_dir <= look_dir + 2'd1;
          if (look_dir == 2'd3) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (pick.any) begin
            new_q <= nb_cell[pick.dir];
            gap_q <= sel_wall;
            state <= S_CELL;
          end else begin
            state <= S_POP;
          end
        end
        S_POP: begin
          if (slot_free) begin
            if (pop_has_below) begin
              top_q <= stack_rdata;
            end
            stack_count <= stack_count - CNTW'(1);
            state       <= S_IDLE;
          end
        end
        S_CELL: begin
          if (slot_free) begin
            if (stack_count < STACK_FULL) begin
              stack_count <= stack_count + CNTW'(1);
              top_q       <= new_q;
            end
            state <= S_IDLE;
          end
        end
        S_READ, S_REPLY: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      status    <= out_status;
      cell_x    <= (state == S_CELL) ? new_q.x : 6'd0;
      cell_y    <= (state == S_CELL) ? new_q.y : 6'd0;
      gap_x     <= (state == S_CELL) ? gap_q.x : 6'd0;
      gap_y     <= (state == S_CELL) ? gap_q.y : 6'd0;
      cell_open <= (state == S_READ) && rd_inrange && map_open;
    end
  end

  // Wall cell sits halfway between the top cell and the new cell
  assign gap_mid = ((7'(gap_q.x) << 1) == (7'(top_q.x) + 7'(new_q.x))) &&
                   ((7'(gap_q.y) << 1) == (7'(top_q.y) + 7'(new_q.y)));

  `DMC_ASSERT_NOW(a_stack_bound, 1'b1, stack_count <= STACK_FULL, "stack count overflow")
  `DMC_ASSERT_NOW(a_epoch_live, state != S_CLEAR, epoch != '0, "epoch zero outside sweep")
  `DMC_ASSERT_NOW(a_out_slot, out_load, !out_valid || out_ready, "result overwrote held beat")
  `DMC_ASSERT_NOW(a_gap_mid, (state == S_CELL) && out_load, gap_mid, "wall not between cells")
  `DMC_ASSERT_NEXT(a_unused_idle, accept && (action == ACT_NONE), state == S_IDLE, "unused action left idle")

endmodule

@@ dv/dfs_maze_carver_tb.sv @@
// Self-checking testbench for the depth-first maze carver: directed and random beats.
`timescale 1ns / 100ps

module dfs_maze_carver_tb;
  import dmc_pkg::*;

  localparam int GRID_MAX    = 64;
  localparam int STACK_DEPTH = 1024;
  localparam int IDLE_LIMIT  = 20000;
  localparam int PHASE_ITEMS = 580;

  // One result beat, laid out as the output ports
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [5:0] gap_x;
    logic [5:0] gap_y;
    logic       cell_open;
  } maze_beat_t;

  // Tracks the carved map and path stack, and checks result beats in order
  class carve_scoreboard;
    bit         open_map [GRID_MAX*GRID_MAX];
    bit [11:0]  path_stack [STACK_DEPTH];
    int         depth;
    int         size;
    int         deepest;
    int         mismatches;
    int         beats_checked;
    int         status_count [8];
    maze_beat_t pending_results [$];

    function new();
      size = 63;
    endfunction

    function void set_size(logic [5:0] v);
      size = int'(v);
    endfunction

    // Predict the result of one accepted input beat
    function void accept_item(action_t act, logic [15:0] rnd, logic [5:0] rx, logic [5:0] ry);
      maze_beat_t res;
      bit [11:0]  top;
      int         x, y, nx, ny, wx, wy, dx, dy, cnt, pick;
      int         cand_dx [4];
      int         cand_dy [4];
      res = '0;
      case (act)
        ACT_START: begin
          if (size < 3 || size % 2 == 0 || size > GRID_MAX) begin
            res.status = ST_REJECT;
          end else begin
            foreach (open_map[i]) open_map[i] = 1'b0;
            open_map[ENTRY_CELL] = 1'b1;
            open_map[START_CELL] = 1'b1;
            open_map[(size - 2) * GRID_MAX + size - 1] = 1'b1;
            path_stack[0] = START_CELL;
            depth = 1;
            res.status = ST_STARTED;
          end
        end
        ACT_STEP: begin
          if (depth == 0) begin
            res.status = ST_DONE;
          end else begin
            top = path_stack[(depth - 1) % STACK_DEPTH];
            x = int'(top[5:0]);
            y = int'(top[11:6]);
            cnt = 0;
            // Scan neighbors two cells away: up, right, down, left
            for (int d = 0; d < 4; d++) begin
              case (2'(d))
                DIR_UP: begin
                  dx = 0;
                  dy = -2;
                end
                DIR_RIGHT: begin
                  dx = 2;
                  dy = 0;
                end
                DIR_DOWN: begin
                  dx = 0;
                  dy = 2;
                end
                default: begin
                  dx = -2;
                  dy = 0;
                end
              endcase
              nx = x + dx;
              ny = y + dy;
              if (nx > 0 && nx < size - 1 && ny > 0 && ny < size - 1 &&
                  nx < GRID_MAX && ny < GRID_MAX && !open_map[ny * GRID_MAX + nx]) begin
                cand_dx[cnt] = dx;
                cand_dy[cnt] = dy;
                cnt++;
              end
            end
            if (cnt == 0) begin
              depth--;
              res.status = ST_BACK;
            end else begin
              pick = int'(rnd) % cnt;
              nx = x + cand_dx[pick];
              ny = y + cand_dy[pick];
              wx = x + cand_dx[pick] / 2;
              wy = y + cand_dy[pick] / 2;
              open_map[wy * GRID_MAX + wx] = 1'b1;
              open_map[ny * GRID_MAX + nx] = 1'b1;
              // Drop the push when the stack is full
              if (depth < STACK_DEPTH) begin
                path_stack[depth] = {6'(ny), 6'(nx)};
                depth++;
              end
              res.status = ST_CARVED;
              res.cell_x = 6'(nx);
              res.cell_y = 6'(ny);
              res.gap_x  = 6'(wx);
              res.gap_y  = 6'(wy);
            end
          end
        end
        ACT_READ: begin
          res.status    = ST_READ;
          res.cell_open = open_map[{ry, rx}];
        end
        default: return;
      endcase
      if (depth > deepest) deepest = depth;
      status_count[res.status]++;
      pending_results.push_back(res);
    endfunction

    // Compare one output beat with the oldest prediction
    function void check_beat(maze_beat_t got);
      maze_beat_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t unexpected result beat, status %0d", $time, got.status);
        return;
      end
      want = pending_results.pop_front();
      beats_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t mismatch: expected status %0d cell (%0d,%0d) gap (%0d,%0d) open %0d",
                   $time, want.status, want.cell_x, want.cell_y, want.gap_x, want.gap_y,
                   want.cell_open);
          $display("%0t            got status %0d cell (%0d,%0d) gap (%0d,%0d) open %0d",
                   $time, got.status, got.cell_x, got.cell_y, got.gap_x, got.gap_y,
                   got.cell_open);
        end
      end
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_we       = 1'b0;
  logic [5:0]  cfg_wdata    = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [1:0]  action       = '0;
  logic [15:0] random_value = '0;
  logic [5:0]  read_x       = '0;
  logic [5:0]  read_y       = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [2:0]  status;
  logic [5:0]  cell_x;
  logic [5:0]  cell_y;
  logic [5:0]  gap_x;
  logic [5:0]  gap_y;
  logic        cell_open;

  int send_idle  = 19;
  int recv_idle  = 74;
  int items_sent = 0;
  int cfg_writes = 0;

  carve_scoreboard maze_sb = new();

  dfs_maze_carver #(
    .MAX_SIDE      (GRID_MAX),
    .STACK_ENTRIES (STACK_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .random_value (random_value),
    .read_x       (read_x),
    .read_y       (read_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .gap_x        (gap_x),
    .gap_y        (gap_y),
    .cell_open    (cell_open)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the receiver at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      maze_sb.check_beat({status, cell_x, cell_y, gap_x, gap_y, cell_open});
    end
  end

  // End the run when no beat moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: %0d cycles without a beat", quiet);
    $display("FAIL");
    $finish;
  end

  // Present one input beat, with random idle cycles ahead of it, and hold until taken
  task automatic send_item(action_t act, logic [15:0] rnd = '0, logic [5:0] rx = '0,
                           logic [5:0] ry = '0);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    random_value <= rnd;
    read_x       <= rx;
    read_y       <= ry;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    maze_sb.accept_item(act, rnd, rx, ry);
    if (act != ACT_NONE) items_sent++;
  endtask

  // Hold off the sender until every result is back and the block is quiet
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (maze_sb.pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_size(logic [5:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    maze_sb.set_size(v);
    cfg_writes++;
  endtask

  initial begin
    int roll, budget, grid, target;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Empty stack, map corners, unused action
    send_item(ACT_STEP, 16'h1234);
    send_item(ACT_READ, 16'hFFFF, 6'd0, 6'd0);
    send_item(ACT_READ, 16'h0000, 6'd63, 6'd63);
    send_item(ACT_NONE, 16'hA5A5, 6'd21, 6'd42);
    // Rejected sizes: even, and below the minimum
    wait_drained();
    write_size(6'd4);
    send_item(ACT_START);
    wait_drained();
    write_size(6'd1);
    send_item(ACT_START);
    // Smallest grid: nothing to carve, backtrack then finish
    wait_drained();
    write_size(6'd3);
    send_item(ACT_START);
    send_item(ACT_STEP, 16'h0000);
    send_item(ACT_STEP, 16'hFFFF);
    send_item(ACT_READ, 16'h0000, 6'd1, 6'd0);
    send_item(ACT_READ, 16'h0000, 6'd2, 6'd1);
    send_item(ACT_READ, 16'h0000, 6'd2, 6'd2);
    wait_drained();
    write_size(6'd5);
    send_item(ACT_START);
    send_item(ACT_STEP, 16'h0000);
    send_item(ACT_STEP, 16'hFFFF);
    send_item(ACT_STEP, 16'h0001);
    send_item(ACT_READ, 16'h0000, 6'd3, 6'd3);
    // Largest grid, exit corner and border
    wait_drained();
    write_size(6'd63);
    send_item(ACT_START);
    send_item(ACT_STEP, 16'hFFFF);
    send_item(ACT_STEP, 16'h0000);
    send_item(ACT_READ, 16'h0000, 6'd62, 6'd61);
    send_item(ACT_READ, 16'hFFFF, 6'd63, 6'd0);
    // Shrink the grid under a maze in progress
    wait_drained();
    write_size(6'd9);
    send_item(ACT_STEP, 16'h0002);
    send_item(ACT_STEP, 16'h0003);

    // Random mazes, one idle pattern per phase
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 19 : (phase == 1) ? 74 : 0;
      recv_idle = (phase == 0) ? 74 : (phase == 1) ? 19 : 0;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        roll = $urandom_range(99);
        if (roll < 8) grid = ($urandom_range(1) == 1) ? $urandom_range(31) * 2 : 1;
        else if (roll < 13) grid = 63;
        else if (roll < 25) grid = $urandom_range(30, 7) * 2 + 1;
        else grid = $urandom_range(6, 1) * 2 + 1;
        wait_drained();
        write_size(6'(grid));
        send_item(ACT_START);
        budget = (grid == 63) ? 120 : 400;
        while (budget > 0 && items_sent < target) begin
          budget--;
          // One step on the empty stack, then move on
          if (maze_sb.depth == 0) begin
            send_item(ACT_STEP, 16'($urandom));
            break;
          end
          roll = $urandom_range(99);
          if (roll < 8) begin
            send_item(ACT_READ, 16'($urandom), 6'($urandom_range(maze_sb.size)),
                      6'($urandom_range(maze_sb.size)));
          end else if (roll < 10) begin
            send_item(ACT_READ, 16'($urandom), 6'($urandom), 6'($urandom));
          end else if (roll < 12) begin
            send_item(ACT_NONE, 16'($urandom), 6'($urandom), 6'($urandom));
          end else if (roll < 13) begin
            send_item(ACT_START, 16'($urandom));
          end else if (roll < 15) begin
            wait_drained();
            write_size(6'($urandom));
          end else begin
            send_item(ACT_STEP, 16'($urandom));
          end
        end
      end
    end

    wait_drained();
    $display("covered %0d items, %0d size writes: %0d carves, %0d backtracks, %0d finished steps",
             items_sent, cfg_writes, maze_sb.status_count[ST_CARVED],
             maze_sb.status_count[ST_BACK], maze_sb.status_count[ST_DONE]);
    $display("%0d starts, %0d rejected sizes, %0d cell reads, deepest path %0d cells",
             maze_sb.status_count[ST_STARTED], maze_sb.status_count[ST_REJECT],
             maze_sb.status_count[ST_READ], maze_sb.deepest);
    if (maze_sb.mismatches == 0 && maze_sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", maze_sb.mismatches,
               maze_sb.pending_results.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ dfs_maze_carver.f @@
+incdir+hw/rtl
hw/rtl/dmc_pkg.sv
hw/rtl/dmc_pick.sv
hw/rtl/dfs_maze_carver.sv
dv/dfs_maze_carver_tb.sv
